[rtl/core/u8dec_pkg.sv]
package u8dec_pkg;

  // One accepted input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [30:0] code_point;
    logic        is_error;
  } result_t;

  localparam logic [30:0] REPL_CODE_POINT  = 31'h0000FFFD;
  localparam logic [7:0]  CONT_BASE        = 8'h80;
  localparam logic [7:0]  LEAD_BASE        = 8'hC0;
  localparam logic [7:0]  LEAD_LIMIT_3     = 8'hE0;
  localparam logic [7:0]  LEAD_LIMIT_4     = 8'hF0;
  localparam logic [7:0]  LEAD_LIMIT_5     = 8'hF8;
  localparam logic [7:0]  LEAD_LIMIT_6     = 8'hFC;

  // Length class codes: sequence of two to six bytes.
  localparam logic [2:0] CLASS_2 = 3'd0;
  localparam logic [2:0] CLASS_3 = 3'd1;
  localparam logic [2:0] CLASS_4 = 3'd2;
  localparam logic [2:0] CLASS_5 = 3'd3;
  localparam logic [2:0] CLASS_6 = 3'd4;

  // Length class of a lead byte (0xC0 or above).
  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] k;
    if (b >= LEAD_LIMIT_6) begin
      k = CLASS_6;
    end else if (b >= LEAD_LIMIT_5) begin
      k = CLASS_5;
    end else if (b >= LEAD_LIMIT_4) begin
      k = CLASS_4;
    end else if (b >= LEAD_LIMIT_3) begin
      k = CLASS_3;
    end else begin
      k = CLASS_2;
    end
    return k;
  endfunction

  // Output mask for a finished sequence; classes above the last use its mask.
  function automatic logic [30:0] class_mask(input logic [2:0] lc);
    logic [30:0] m;
    case (lc)
      CLASS_2: m = 31'h000007FF;
      CLASS_3: m = 31'h0000FFFF;
      CLASS_4: m = 31'h001FFFFF;
      CLASS_5: m = 31'h03FFFFFF;
      default: m = 31'h7FFFFFFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/core/u8dec_in_reg.sv]
module u8dec_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8dec_pkg::item_t  in_item,
  input  logic              take,
  output logic              item_valid,
  output u8dec_pkg::item_t  item
);

  logic             valid_r;
  logic             valid_nxt;
  u8dec_pkg::item_t item_r;

  // The register refills in the same cycle its transaction is taken.
  assign in_ready   = !valid_r || take;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/core/u8dec_core.sv]
module u8dec_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  u8dec_pkg::item_t   item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output u8dec_pkg::result_t out_result
);

  logic [2:0]         bytes_left_r;
  logic [2:0]         bytes_left_nxt;
  logic [2:0]         length_class_r;
  logic [2:0]         length_class_nxt;
  logic [30:0]        acc_r;
  logic [30:0]        acc_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  u8dec_pkg::result_t out_result_r;
  u8dec_pkg::result_t res_nxt;
  logic               emit;
  logic [30:0]        acc_shift;

  // The held item moves on whenever the result register is free or draining.
  assign take = item_valid && (!out_valid_r || out_ready);

  assign acc_shift = {acc_r[24:0], item.data_byte[5:0]};

  // Decode one byte against the sequence state.
  always_comb begin
    bytes_left_nxt   = bytes_left_r;
    length_class_nxt = length_class_r;
    acc_nxt          = acc_r;
    emit             = 1'b0;
    res_nxt.code_point = u8dec_pkg::REPL_CODE_POINT;
    res_nxt.is_error   = 1'b1;
    if (bytes_left_r == 3'd0) begin
      if (!item.end_of_stream) begin
        if (item.data_byte < u8dec_pkg::CONT_BASE) begin
          emit               = 1'b1;
          res_nxt.code_point = {23'd0, item.data_byte};
          res_nxt.is_error   = 1'b0;
        end else if (item.data_byte < u8dec_pkg::LEAD_BASE) begin
          emit = 1'b1;
        end else begin
          length_class_nxt = u8dec_pkg::lead_class(item.data_byte);
          bytes_left_nxt   = u8dec_pkg::lead_class(item.data_byte) + 3'd1;
          acc_nxt          = {23'd0, item.data_byte};
        end
      end
    end else if (item.end_of_stream) begin
      // Sequence cut off by the end of the stream.
      emit             = 1'b1;
      bytes_left_nxt   = 3'd0;
      length_class_nxt = u8dec_pkg::CLASS_2;
      acc_nxt          = 31'd0;
    end else begin
      bytes_left_nxt = bytes_left_r - 3'd1;
      acc_nxt        = acc_shift;
      if (bytes_left_r == 3'd1) begin
        emit               = 1'b1;
        res_nxt.code_point = acc_shift & u8dec_pkg::class_mask(length_class_r);
        res_nxt.is_error   = 1'b0;
        length_class_nxt   = u8dec_pkg::CLASS_2;
        acc_nxt            = 31'd0;
      end
    end
  end

  assign out_valid_nxt = (take && emit) || (out_valid_r && !out_ready);

  // Sequence state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r   <= 3'd0;
      length_class_r <= u8dec_pkg::CLASS_2;
      acc_r          <= 31'd0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        bytes_left_r   <= bytes_left_nxt;
        length_class_r <= length_class_nxt;
        acc_r          <= acc_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_result_r <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

[rtl/core/utf8_byte_stream_decoder.sv]
// UTF-8 byte stream decoder for the original six-byte form.
// Input channel: in_valid/in_ready carry one byte (in_data_byte) per
// transaction, or an end-of-stream marker (in_end_of_stream = 1).
// Result channel: out_valid/out_ready carry one code point (out_code_point)
// and an error flag (out_is_error); a transaction gives zero or one result.
// ASCII bytes give themselves, a stray continuation byte gives 0xFFFD with
// the error flag, and a lead byte starts a sequence of one to five further
// bytes whose low six bits are gathered. An end marker inside a sequence
// gives the flagged 0xFFFD; outside one it gives nothing.
// The input transaction loads the input register, and the decode then loads
// the result register, which drives out_valid. Throughput is one byte per
// cycle while the receiver does not stall, set by the single pass from input
// register to result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to the idle state between sequences.
// When the receiver stalls, the result register holds; one more byte waits
// in the input register and in_ready then drops until out_ready returns.
module utf8_byte_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_code_point,
  output logic        out_is_error
);

  u8dec_pkg::item_t   in_item;
  u8dec_pkg::item_t   item;
  u8dec_pkg::result_t result;
  logic               item_valid;
  logic               take;

  assign in_item.data_byte     = in_data_byte;
  assign in_item.end_of_stream = in_end_of_stream;

  u8dec_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  u8dec_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign out_code_point = result.code_point;
  assign out_is_error   = result.is_error;

endmodule

[sim/utf8_byte_stream_decoder_tb.sv]
module utf8_byte_stream_decoder_tb;

  localparam int RANDOM_ITEMS = 1550;
  localparam int IDLE_PCT     = 19;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 1000;
  localparam int DRAIN_CYCLES = 8;

  // Tracks the decoder state and holds the code points still owed by the block.
  class code_point_tracker;
    u8dec_pkg::result_t pending_points[$];
    logic [2:0]  seq_left;
    logic [2:0]  seq_class;
    logic [30:0] seq_bits;
    int          n_items;
    int          n_points;
    int          n_replacements;
    int          n_failures;

    function new();
      seq_left       = '0;
      seq_class      = u8dec_pkg::CLASS_2;
      seq_bits       = '0;
      n_items        = 0;
      n_points       = 0;
      n_replacements = 0;
      n_failures     = 0;
    endfunction

    // Width of the code point that a finished sequence of this class carries.
    function logic [30:0] width_mask(input logic [2:0] lc);
      int bits;
      if (lc >= u8dec_pkg::CLASS_6) begin
        bits = 31;
      end else begin
        bits = 11 + 5 * int'(lc);
      end
      return (31'd1 << bits) - 31'd1;
    endfunction

    function void owe(input logic [30:0] cp, input logic err);
      u8dec_pkg::result_t r;
      r.code_point = cp;
      r.is_error   = err;
      pending_points.push_back(r);
    endfunction

    // Advances the decoder by one accepted input transaction.
    function void take_byte(input logic [7:0] b, input logic eos);
      logic [2:0] k;
      n_items++;
      if (seq_left == 0) begin
        if (eos) begin
          return;
        end
        if (b < u8dec_pkg::CONT_BASE) begin
          owe({23'd0, b}, 1'b0);
        end else if (b < u8dec_pkg::LEAD_BASE) begin
          owe(u8dec_pkg::REPL_CODE_POINT, 1'b1);
        end else begin
          k = u8dec_pkg::CLASS_2;
          if (b >= u8dec_pkg::LEAD_LIMIT_3) k = u8dec_pkg::CLASS_3;
          if (b >= u8dec_pkg::LEAD_LIMIT_4) k = u8dec_pkg::CLASS_4;
          if (b >= u8dec_pkg::LEAD_LIMIT_5) k = u8dec_pkg::CLASS_5;
          if (b >= u8dec_pkg::LEAD_LIMIT_6) k = u8dec_pkg::CLASS_6;
          seq_class = k;
          seq_left  = k + 3'd1;
          seq_bits  = {23'd0, b};
        end
      end else if (eos) begin
        // A sequence cut short by the end marker.
        seq_left  = '0;
        seq_class = u8dec_pkg::CLASS_2;
        seq_bits  = '0;
        owe(u8dec_pkg::REPL_CODE_POINT, 1'b1);
      end else begin
        // Any byte inside a sequence counts as a continuation byte.
        seq_bits = {seq_bits[24:0], b[5:0]};
        seq_left = seq_left - 3'd1;
        if (seq_left == 0) begin
          owe(seq_bits & width_mask(seq_class), 1'b0);
          seq_class = u8dec_pkg::CLASS_2;
          seq_bits  = '0;
        end
      end
    endfunction

    // Compares one result transaction with the oldest owed code point.
    function void match_result(input logic [30:0] cp, input logic err);
      u8dec_pkg::result_t want;
      if (pending_points.size() == 0) begin
        $error("unexpected result: code_point %h is_error %0b", cp, err);
        n_failures++;
        return;
      end
      want = pending_points.pop_front();
      n_points++;
      if (err) n_replacements++;
      if (cp !== want.code_point) begin
        $error("code_point mismatch: expected %h, actual %h", want.code_point, cp);
        n_failures++;
      end
      if (err !== want.is_error) begin
        $error("is_error mismatch: expected %0b, actual %0b", want.is_error, err);
        n_failures++;
      end
    endfunction
  endclass

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte     = 8'h00;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [30:0] out_code_point;
  logic        out_is_error;
  logic        calm             = 1'b0;

  code_point_tracker tracker = new();

  utf8_byte_stream_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_is_error     (out_is_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every result transaction goes to the tracker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.match_result(out_code_point, out_is_error);
    end
  end

  // Offers one transaction and returns at the falling edge after it is taken.
  task automatic send_item(input logic [7:0] b, input logic eos);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_data_byte     = b;
    in_end_of_stream = eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_byte(b, eos);
    @(negedge clk);
  endtask

  // Picks a lead byte from the range that selects the given length class.
  function automatic logic [7:0] pick_lead(input logic [2:0] lc);
    case (lc)
      u8dec_pkg::CLASS_2:
        return 8'($urandom_range(u8dec_pkg::LEAD_BASE, u8dec_pkg::LEAD_LIMIT_3 - 8'd1));
      u8dec_pkg::CLASS_3:
        return 8'($urandom_range(u8dec_pkg::LEAD_LIMIT_3, u8dec_pkg::LEAD_LIMIT_4 - 8'd1));
      u8dec_pkg::CLASS_4:
        return 8'($urandom_range(u8dec_pkg::LEAD_LIMIT_4, u8dec_pkg::LEAD_LIMIT_5 - 8'd1));
      u8dec_pkg::CLASS_5:
        return 8'($urandom_range(u8dec_pkg::LEAD_LIMIT_5, u8dec_pkg::LEAD_LIMIT_6 - 8'd1));
      default:
        return 8'($urandom_range(u8dec_pkg::LEAD_LIMIT_6, 8'hFF));
    endcase
  endfunction

  // One random chunk of stream: mostly whole sequences, some noise.
  task automatic send_random_chunk();
    int         pick;
    int         cut_at;
    logic [2:0] lc;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      lc = 3'($urandom_range(u8dec_pkg::CLASS_2, u8dec_pkg::CLASS_6));
      cut_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, int'(lc)) : -1;
      send_item(pick_lead(lc), 1'b0);
      for (int i = 0; i <= int'(lc); i++) begin
        if (i == cut_at) begin
          send_item(8'($urandom), 1'b1);
          break;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom), 1'b0);
        end else begin
          send_item(8'($urandom_range(u8dec_pkg::CONT_BASE,
                                      u8dec_pkg::LEAD_BASE - 8'd1)), 1'b0);
        end
      end
    end else if (pick < 80) begin
      send_item(8'($urandom_range(0, u8dec_pkg::CONT_BASE - 8'd1)), 1'b0);
    end else if (pick < 88) begin
      send_item(8'($urandom_range(u8dec_pkg::CONT_BASE,
                                  u8dec_pkg::LEAD_BASE - 8'd1)), 1'b0);
    end else if (pick < 94) begin
      send_item(8'($urandom), 1'b1);
    end else begin
      send_item(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int directed_count;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // ASCII extremes, stray continuation bytes, end marker while idle.
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hFF, 1'b1);
    // Shortest class at both ends of the payload.
    send_item(8'hC0, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hDF, 1'b0);
    send_item(8'hBF, 1'b0);
    // Three bytes, with an ASCII byte swallowed as a continuation.
    send_item(8'hEF, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'h7F, 1'b0);
    // Four bytes, with top bits of the continuations ignored.
    send_item(8'hF7, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hC0, 1'b0);
    // Five and six bytes at full width.
    send_item(8'hFB, 1'b0);
    repeat (4) send_item(8'hBF, 1'b0);
    send_item(8'hFF, 1'b0);
    repeat (5) send_item(8'hFF, 1'b0);
    // End marker inside a sequence.
    send_item(8'hFC, 1'b0);
    send_item(8'h00, 1'b1);

    directed_count = tracker.n_items;
    while (tracker.n_items < directed_count + RANDOM_ITEMS) begin
      calm = (tracker.n_items >= CALM_FROM) && (tracker.n_items < CALM_TO);
      send_random_chunk();
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    while (tracker.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes and end markers over all five sequence lengths.",
             tracker.n_items);
    $display("Checked %0d code points, %0d of them replacement characters.",
             tracker.n_points, tracker.n_replacements);
    if (tracker.n_failures == 0 && tracker.pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_in_reg.sv
rtl/core/u8dec_core.sv
rtl/core/utf8_byte_stream_decoder.sv
sim/utf8_byte_stream_decoder_tb.sv
